[sv/spa_pkg.sv]
// Shared types and codes for the slot pool allocator.
package spa_pkg;

  localparam int SLOT_W = 11;
  localparam int WORD_W = 64;

  // Operation codes carried in the func field.
  localparam logic [1:0] FUNC_SAVE  = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_GET   = 2'd2;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  // Result status codes.
  localparam logic [1:0] STATUS_FINE        = 2'd0;
  localparam logic [1:0] STATUS_FULL        = 2'd1;
  localparam logic [1:0] STATUS_DOUBLE_FREE = 2'd2;
  localparam logic [1:0] STATUS_NEVER_ALLOC = 2'd3;

  localparam logic [SLOT_W-1:0] MAX_SLOTS_RESET = 11'd1024;

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } ctl_state_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [SLOT_W-1:0] slot_index;
    logic [WORD_W-1:0] value_word;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] given_index;
    logic [WORD_W-1:0] read_value;
    logic              read_valid;
    logic [1:0]        status;
    logic [SLOT_W-1:0] in_use;
  } out_item_t;

endpackage

[sv/spa_ram.sv]
// Simple dual-port synchronous RAM with registered read.
module spa_ram
  import spa_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data when no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/slot_pool_allocator.sv]
// Top level of the slot pool allocator: control, counters and output register.
//
// A pool of POOL_DEPTH slots, each holding a VALUE_BITS value word, with a LIFO
// free stack. Every input transfer is one operation: save (reuse the most
// recently freed slot, else the next fresh slot up to min(max_slots,
// POOL_DEPTH)), free (push a slot on the free stack) or get (read a slot back).
// A slot_index equal to max_slots is the sentinel and does nothing. Each
// operation has an accept cycle, which issues reads of the slot memory
// (value plus free flag) and of the free-stack top, and an execute cycle, which
// checks the flags and counters, writes the slot memory and the stack, and
// loads the output register. One operation is in flight at a time, so every
// read sees all earlier writes. The next operation is accepted while a result
// still waits in the output register; if that result is still not taken when
// the next operation finishes its reads, execution holds until it is. The free
// flags need no clearing pass after reset: only slots below the fresh count are
// ever looked at, and a slot's flag is written clear when it is first handed
// out. max_slots may be written only while the block is idle.
module slot_pool_allocator
  import spa_pkg::*;
#(
  parameter int POOL_DEPTH = 1024,
  parameter int VALUE_BITS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item,
  input  logic              cfg_we,
  input  logic [SLOT_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(POOL_DEPTH);

  // Control and counters.
  ctl_state_t        state, state_next;
  logic [SLOT_W-1:0] max_slots;
  logic [SLOT_W-1:0] fresh_count, fresh_count_next;
  logic [SLOT_W-1:0] free_count, free_count_next;
  logic              out_valid_next;
  logic              commit;
  logic              accept;
  in_item_t          item;
  out_item_t         res;

  // Memory ports.
  logic [VALUE_BITS:0]   slot_rdata;
  logic                  slot_we;
  logic [AW-1:0]         slot_waddr;
  logic [VALUE_BITS:0]   slot_wdata;
  logic [AW-1:0]         stk_rdata;
  logic                  stk_we;
  logic [AW-1:0]         stk_waddr;
  logic [AW-1:0]         stk_wdata;

  // Slot memory entry: free flag on top, value word below.
  spa_ram #(
    .DEPTH (POOL_DEPTH),
    .WIDTH (VALUE_BITS + 1)
  ) u_slot_ram (
    .clk   (clk),
    .re    (accept),
    .raddr (AW'(in_item.slot_index)),
    .rdata (slot_rdata),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata)
  );

  // Free stack; the read always targets the current top.
  spa_ram #(
    .DEPTH (POOL_DEPTH),
    .WIDTH (AW)
  ) u_stack_ram (
    .clk   (clk),
    .re    (accept),
    .raddr (AW'(free_count - SLOT_W'(1))),
    .rdata (stk_rdata),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata)
  );

  assign accept = in_valid && in_ready;

  // Sequencer: accept, then execute once the output register has room.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    commit     = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid || out_ready) begin
          commit     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Execute: decide the result and the writes from the read data.
  always_comb begin
    logic              flag;
    logic              fresh_full;
    logic              stack_has;
    logic              idx_bad;
    logic [VALUE_BITS-1:0] new_val;

    flag       = slot_rdata[VALUE_BITS];
    new_val    = item.value_word[VALUE_BITS-1:0];
    fresh_full = (fresh_count >= max_slots) ||
                 (32'(fresh_count) >= 32'(POOL_DEPTH));
    stack_has  = (free_count != '0) && (32'(free_count) <= 32'(POOL_DEPTH));
    idx_bad    = (item.slot_index >= fresh_count) ||
                 (32'(item.slot_index) >= 32'(POOL_DEPTH));

    res.ok          = 1'b1;
    res.given_index = max_slots;
    res.read_value  = '0;
    res.read_valid  = 1'b0;
    res.status      = STATUS_FINE;

    fresh_count_next = fresh_count;
    free_count_next  = free_count;
    slot_we    = 1'b0;
    slot_waddr = AW'(item.slot_index);
    slot_wdata = {1'b1, slot_rdata[VALUE_BITS-1:0]};
    stk_we     = 1'b0;
    stk_waddr  = AW'(free_count);
    stk_wdata  = AW'(item.slot_index);

    case (item.func)
      FUNC_SAVE: begin
        if (stack_has) begin
          // Pop the most recently freed slot and clear its flag.
          free_count_next = free_count - SLOT_W'(1);
          slot_we         = 1'b1;
          slot_waddr      = stk_rdata;
          slot_wdata      = {1'b0, new_val};
          res.given_index = SLOT_W'(stk_rdata);
        end else if (fresh_full) begin
          res.ok     = 1'b0;
          res.status = STATUS_FULL;
        end else begin
          fresh_count_next = fresh_count + SLOT_W'(1);
          slot_we          = 1'b1;
          slot_waddr       = AW'(fresh_count);
          slot_wdata       = {1'b0, new_val};
          res.given_index  = fresh_count;
        end
      end
      FUNC_FREE, FUNC_GET: begin
        if (item.slot_index == max_slots) begin
          // Sentinel: nothing to do.
        end else if (idx_bad) begin
          res.ok     = 1'b0;
          res.status = STATUS_NEVER_ALLOC;
        end else if (item.func == FUNC_GET) begin
          res.read_value = WORD_W'(slot_rdata[VALUE_BITS-1:0]);
          res.read_valid = 1'b1;
        end else if (flag) begin
          res.ok     = 1'b0;
          res.status = STATUS_DOUBLE_FREE;
        end else if (32'(free_count) < 32'(POOL_DEPTH)) begin
          // Push on the stack and mark the slot, keeping its value.
          free_count_next = free_count + SLOT_W'(1);
          stk_we          = 1'b1;
          slot_we         = 1'b1;
        end
      end
      default: begin
        // Unused code: no change.
      end
    endcase

    if (!commit) begin
      slot_we          = 1'b0;
      stk_we           = 1'b0;
      fresh_count_next = fresh_count;
      free_count_next  = free_count;
    end

    res.in_use = fresh_count_next - free_count_next;
  end

  // Drop the result once taken; load a new one on commit.
  always_comb begin
    out_valid_next = out_valid;
    if (commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      fresh_count <= '0;
      free_count  <= '0;
      max_slots   <= MAX_SLOTS_RESET;
    end else begin
      state       <= state_next;
      out_valid   <= out_valid_next;
      fresh_count <= fresh_count_next;
      free_count  <= free_count_next;
      if (cfg_we) begin
        max_slots <= cfg_wdata;
      end
    end
  end

  // Payload registers: hold the accepted item and the pending result.
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
    end
    if (commit) begin
      out_item <= res;
    end
  end

endmodule

[tb/testbench.sv]
// Self-checking testbench for the slot pool allocator with its own pool predictor.
module testbench;
  import spa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_SLOTS   = 1024;
  localparam int HOLD_CYCLES  = 200;
  localparam int SHOW_LIMIT   = 10;
  localparam int ANSWER_DEPTH = 16;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_item = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_item;
  logic              cfg_we = 1'b0;
  logic [SLOT_W-1:0] cfg_wdata = '0;

  slot_pool_allocator DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Free-running clock, 12 ns period.
  initial begin
    forever #6 clk = ~clk;
  end

  // Predicted pool contents: value per slot, LIFO free stack, freed flags and counters.
  logic [WORD_W-1:0] slot_value [POOL_SLOTS];
  int unsigned       free_stack_m [POOL_SLOTS];
  bit                slot_freed [POOL_SLOTS];
  int unsigned       fresh_n = 0;
  int unsigned       freed_n = 0;
  logic [SLOT_W-1:0] slot_limit = MAX_SLOTS_RESET;

  // Answers the pool owes, oldest first.
  out_item_t   answer_ring [ANSWER_DEPTH];
  int unsigned answer_wr = 0;
  int unsigned answer_rd = 0;

  int fault_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic stall_hold = 1'b0;
  event hold_go;

  // Apply one operation to the predicted pool and return the answer it must give.
  function automatic out_item_t predict_pool_op(in_item_t op);
    out_item_t   r;
    int unsigned idx;
    int unsigned s;
    int unsigned cap;
    idx = 32'(op.slot_index);
    cap = (32'(slot_limit) < POOL_SLOTS) ? 32'(slot_limit) : 32'(POOL_SLOTS);
    r.ok          = 1'b1;
    r.given_index = slot_limit;
    r.read_value  = '0;
    r.read_valid  = 1'b0;
    r.status      = STATUS_FINE;
    case (op.func)
      FUNC_SAVE: begin
        if (freed_n > 0) begin
          // Reuse the most recently freed slot first.
          freed_n--;
          s = free_stack_m[freed_n];
          slot_freed[s] = 1'b0;
          slot_value[s] = op.value_word;
          r.given_index = SLOT_W'(s);
        end else if (fresh_n >= cap) begin
          r.ok     = 1'b0;
          r.status = STATUS_FULL;
        end else begin
          slot_value[fresh_n] = op.value_word;
          r.given_index = SLOT_W'(fresh_n);
          fresh_n++;
        end
      end
      FUNC_FREE, FUNC_GET: begin
        if (op.slot_index == slot_limit) begin
          // Sentinel index: nothing happens.
        end else if (idx >= fresh_n || idx >= POOL_SLOTS) begin
          r.ok     = 1'b0;
          r.status = STATUS_NEVER_ALLOC;
        end else if (op.func == FUNC_GET) begin
          r.read_value = slot_value[idx];
          r.read_valid = 1'b1;
        end else if (slot_freed[idx]) begin
          r.ok     = 1'b0;
          r.status = STATUS_DOUBLE_FREE;
        end else if (freed_n < POOL_SLOTS) begin
          free_stack_m[freed_n] = idx;
          freed_n++;
          slot_freed[idx] = 1'b1;
        end
      end
      default: begin
        // Unused code: answer fine, change nothing.
      end
    endcase
    r.in_use = SLOT_W'(fresh_n - freed_n);
    return r;
  endfunction

  // Offer one operation and hold it until the transfer; predict at acceptance.
  task automatic offer_op(in_item_t op);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= op;
    do @(posedge clk); while (!in_ready);
    answer_ring[answer_wr % ANSWER_DEPTH] = predict_pool_op(op);
    answer_wr++;
  endtask

  task automatic offer_fields(logic [1:0] f, logic [SLOT_W-1:0] idx, logic [WORD_W-1:0] val);
    in_item_t op;
    op.func       = f;
    op.slot_index = idx;
    op.value_word = val;
    offer_op(op);
  endtask

  // Drain every owed answer, let the block settle, then write the slot limit.
  task automatic write_slot_limit(logic [SLOT_W-1:0] v);
    in_valid <= 1'b0;
    while (answer_wr != answer_rd) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    slot_limit = v;
  endtask

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Pick a slot: mostly ones already handed out, sometimes the sentinel or noise.
  function automatic logic [SLOT_W-1:0] random_slot();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80 && fresh_n > 0)
      return SLOT_W'($urandom_range(0, fresh_n - 1));
    else if (pick < 90)
      return slot_limit;
    else
      return SLOT_W'($urandom_range(0, 2047));
  endfunction

  function automatic in_item_t random_op();
    in_item_t op;
    int pick;
    pick = $urandom_range(0, 99);
    op.value_word = random_word();
    op.slot_index = random_slot();
    if (pick < 40)
      op.func = FUNC_SAVE;
    else if (pick < 65)
      op.func = FUNC_FREE;
    else if (pick < 96)
      op.func = FUNC_GET;
    else
      op.func = FUNC_SPARE;
    return op;
  endfunction

  // Extremes, sentinel, never-allocated, double free, unused code and LIFO reuse.
  task automatic test_directed_ops();
    offer_fields(FUNC_SAVE, 11'd0, '0);
    offer_fields(FUNC_SAVE, 11'd0, '1);
    offer_fields(FUNC_GET, 11'd0, '0);
    offer_fields(FUNC_GET, 11'd1, '0);
    offer_fields(FUNC_GET, 11'd1024, '0);
    offer_fields(FUNC_FREE, 11'd1024, '1);
    offer_fields(FUNC_GET, 11'd2, '0);
    offer_fields(FUNC_FREE, 11'd2047, '0);
    offer_fields(FUNC_SPARE, 11'd2047, '1);
    offer_fields(FUNC_FREE, 11'd1, '0);
    offer_fields(FUNC_FREE, 11'd1, '0);
    offer_fields(FUNC_GET, 11'd1, '0);
    offer_fields(FUNC_FREE, 11'd0, '0);
    offer_fields(FUNC_SAVE, 11'd1023, 64'h0123_4567_89ab_cdef);
    offer_fields(FUNC_SAVE, 11'd0, 64'hfedc_ba98_7654_3210);
    offer_fields(FUNC_SAVE, 11'd0, 64'h5555_aaaa_5555_aaaa);
  endtask

  // Lower the limit below the fresh count, then zero, then one.
  task automatic test_limit_edges();
    write_slot_limit(11'd2);
    offer_fields(FUNC_SAVE, 11'd0, 64'h1);
    offer_fields(FUNC_FREE, 11'd2, '0);
    offer_fields(FUNC_FREE, 11'd1, '0);
    offer_fields(FUNC_SAVE, 11'd0, 64'h2);
    write_slot_limit(11'd0);
    offer_fields(FUNC_SAVE, 11'd0, 64'h3);
    offer_fields(FUNC_GET, 11'd0, '0);
    offer_fields(FUNC_GET, 11'd1, '0);
    write_slot_limit(11'd1);
    offer_fields(FUNC_SAVE, 11'd0, 64'h4);
    offer_fields(FUNC_GET, 11'd1, '0);
  endtask

  // Hold the receiver off while the sender keeps offering, so the input stalls.
  task automatic test_backpressure_fill();
    write_slot_limit(11'd6);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    -> hold_go;
    repeat (40) offer_op(random_op());
  endtask

  task automatic test_random_traffic(logic [SLOT_W-1:0] lim, int idle_pct, int stall_pct,
                                     int count);
    write_slot_limit(lim);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) offer_op(random_op());
  endtask

  // Long receiver hold-off, counted here in cycles.
  initial begin
    forever begin
      @(hold_go);
      stall_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      stall_hold <= 1'b0;
    end
  end

  // Receiver: check every result transfer against the oldest owed answer, then
  // drive ready for the next edge.
  initial begin
    out_item_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (answer_wr == answer_rd) begin
          fault_count++;
          if (fault_count <= SHOW_LIMIT)
            $display("unexpected result: got ok=%0d idx=%0d val=%h rv=%0d st=%0d use=%0d",
                     out_item.ok, out_item.given_index, out_item.read_value,
                     out_item.read_valid, out_item.status, out_item.in_use);
        end else begin
          want = answer_ring[answer_rd % ANSWER_DEPTH];
          answer_rd++;
          if (out_item.ok !== want.ok || out_item.given_index !== want.given_index ||
              out_item.read_value !== want.read_value ||
              out_item.read_valid !== want.read_valid ||
              out_item.status !== want.status || out_item.in_use !== want.in_use) begin
            fault_count++;
            if (fault_count <= SHOW_LIMIT) begin
              $display("mismatch: exp ok=%0d idx=%0d val=%h rv=%0d st=%0d use=%0d",
                       want.ok, want.given_index, want.read_value, want.read_valid,
                       want.status, want.in_use);
              $display("          got ok=%0d idx=%0d val=%h rv=%0d st=%0d use=%0d",
                       out_item.ok, out_item.given_index, out_item.read_value,
                       out_item.read_valid, out_item.status, out_item.in_use);
            end
          end
        end
      end
      out_ready <= !stall_hold && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed_ops();
    test_limit_edges();
    test_backpressure_fill();
    test_random_traffic(11'd12, 0, 0, 250);
    test_random_traffic(11'd24, 52, 0, 250);
    test_random_traffic(11'd7, 0, 52, 250);
    test_random_traffic(11'd1024, 9, 9, 250);

    // Drain the remaining answers, then let the block idle to catch strays.
    in_valid <= 1'b0;
    while (answer_wr != answer_rd) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
